// ===== hdl/rcfu_pkg.sv =====
// Shared constants and field widths for the RC frame channel unpacker.
package rcfu_pkg;

   // Field widths fixed by the frame format.
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 5;
   localparam int INDEX_W     = 4;
   localparam int VALUE_W     = 11;
   localparam int CSR_INDEX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_MARKER  = 1'b1;

   // Register reset values.
   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hF0;
   localparam logic [BYTE_W-1:0] STOP_MARKER_RESET  = 8'h00;

   // Default frame geometry.
   localparam int FRAME_BYTES_DEF   = 22;
   localparam int CHANNEL_COUNT_DEF = 16;
   localparam int CHANNEL_BITS_DEF  = 11;

endpackage

// ===== hdl/rcfu_unpack.sv =====
// Bit-serial channel extractor: walks the frame one bit per cycle, waiting on
// a stalled output, and delivers one channel value per output transfer.
module rcfu_unpack #(
   parameter int CHANNEL_COUNT = rcfu_pkg::CHANNEL_COUNT_DEF,
   parameter int CHANNEL_BITS  = rcfu_pkg::CHANNEL_BITS_DEF,
   parameter int POS_W         = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        frame_bit,
   output logic [POS_W-1:0]            bit_pos,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rcfu_pkg::INDEX_W-1:0] rsp_channel_index,
   output logic [rcfu_pkg::VALUE_W-1:0] rsp_channel_value,
   output logic                        rsp_last_channel
);
   import rcfu_pkg::*;

   localparam int BC_W = (CHANNEL_BITS > 1) ? $clog2(CHANNEL_BITS) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SHIFT = 2'd1;
   localparam logic [1:0] ST_PUSH  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [BC_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [INDEX_W-1:0] chan_ff, chan_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_last_ff, out_last_in;
   logic               out_free;
   logic               chan_last;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign chan_last = (chan_ff == INDEX_W'(CHANNEL_COUNT - 1));

   // Sequencer: shift in one channel, then hand it to the output register.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      bit_cnt_in   = bit_cnt_ff;
      chan_in      = chan_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_SHIFT;
               pos_in     = '0;
               bit_cnt_in = '0;
               chan_in    = '0;
               acc_in     = '0;
            end
         end
         ST_SHIFT: begin
            // Wider channels keep only the low value bits as they shift.
            acc_in     = {acc_ff[VALUE_W-2:0], frame_bit};
            pos_in     = pos_ff + POS_W'(1);
            bit_cnt_in = bit_cnt_ff + BC_W'(1);
            if (bit_cnt_ff == BC_W'(CHANNEL_BITS - 1)) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_index_in = chan_ff;
               out_value_in = acc_ff;
               out_last_in  = chan_last;
               acc_in       = '0;
               bit_cnt_in   = '0;
               chan_in      = chan_ff + INDEX_W'(1);
               state_in     = chan_last ? ST_IDLE : ST_SHIFT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      bit_cnt_ff   <= bit_cnt_in;
      chan_ff      <= chan_in;
      acc_ff       <= acc_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   // The next position goes out so that the registered store read lines up
   // with pos_ff in the following cycle.
   assign bit_pos           = pos_in;
   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = out_valid_ff;
   assign rsp_channel_index = out_index_ff;
   assign rsp_channel_value = out_value_ff;
   assign rsp_last_channel  = out_last_ff;

endmodule

// ===== hdl/rc_frame_channel_unpacker.sv =====
// Top level of the RC frame channel unpacker: byte capture, markers, decode.
//
// Usage: received bytes arrive on the req_ channel, one per transfer. A byte
// equal to the start marker clears the byte count; any other non-stop byte is
// stored at the count, which saturates one past FRAME_BYTES so that overlong
// frames are rejected. A stop byte with exactly FRAME_BYTES bytes held starts
// a decode: the frame is read as an MSB-first bit string and CHANNEL_COUNT
// channels of CHANNEL_BITS bits leave on the rsp_ channel, in order, with
// rsp_last_channel set on the final one.
// A decode walks the frame one bit per cycle through a single shift
// accumulator, pausing after each channel's CHANNEL_BITS bits to load it
// into the output register; the first channel follows the stop byte once
// its bits are shifted in. req_stall stays high while a decode runs.
// A stalled receiver holds the current channel in the output register,
// and the decode pauses before loading the next channel until it is taken.
// Reset clears the byte count and output valid, sets the markers (start 0xF0,
// stop 0x00). The csr_ port is always ready; write it only while idle.
module rc_frame_channel_unpacker #(
   parameter int FRAME_BYTES   = rcfu_pkg::FRAME_BYTES_DEF,
   parameter int CHANNEL_COUNT = rcfu_pkg::CHANNEL_COUNT_DEF,
   parameter int CHANNEL_BITS  = rcfu_pkg::CHANNEL_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rcfu_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rcfu_pkg::INDEX_W-1:0]    rsp_channel_index,
   output logic [rcfu_pkg::VALUE_W-1:0]    rsp_channel_value,
   output logic                            rsp_last_channel,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rcfu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rcfu_pkg::BYTE_W-1:0]     csr_data
);
   import rcfu_pkg::*;

   localparam int TOTAL_BITS = CHANNEL_COUNT * CHANNEL_BITS;
   localparam int POS_W      = ($clog2(TOTAL_BITS) > 3) ? $clog2(TOTAL_BITS) : 4;
   localparam int IDX_W      = $clog2(FRAME_BYTES);

   logic [BYTE_W-1:0]  start_marker_ff, start_marker_in;
   logic [BYTE_W-1:0]  stop_marker_ff, stop_marker_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  store_ff [FRAME_BYTES];

   logic               req_xfer;
   logic               hit_start;
   logic               hit_stop;
   logic               store_wr;
   logic               decode_start;
   logic               busy;
   logic [POS_W-1:0]   bit_pos;
   logic [POS_W-4:0]   byte_sel;
   logic               frame_bit_ff;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = busy;
   assign csr_ready = 1'b1;
   assign hit_start = (req_rx_byte == start_marker_ff);
   assign hit_stop  = (req_rx_byte == stop_marker_ff);

   // Configuration writes.
   always_comb begin
      start_marker_in = start_marker_ff;
      stop_marker_in  = stop_marker_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_in = csr_data;
            CSR_STOP_MARKER:  stop_marker_in  = csr_data;
            default:          start_marker_in = start_marker_ff;
         endcase
      end
   end

   // Byte classification; the start marker wins when both markers match.
   always_comb begin
      count_in     = count_ff;
      store_wr     = 1'b0;
      decode_start = 1'b0;
      if (req_xfer) begin
         priority if (hit_start) begin
            count_in = '0;
         end else if (!hit_stop) begin
            if (count_ff < COUNT_W'(FRAME_BYTES)) begin
               store_wr = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end else begin
               count_in = COUNT_W'(FRAME_BYTES + 1);
            end
         end else begin
            decode_start = (count_ff == COUNT_W'(FRAME_BYTES));
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         stop_marker_ff  <= STOP_MARKER_RESET;
         count_ff        <= '0;
      end else begin
         start_marker_ff <= start_marker_in;
         stop_marker_ff  <= stop_marker_in;
         count_ff        <= count_in;
      end
   end

   // Frame store, written at the byte count.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[count_ff[IDX_W-1:0]] <= req_rx_byte;
      end
   end

   // Bit picker, read at the clock edge: bits past the end of the frame read as zero.
   assign byte_sel = bit_pos[POS_W-1:3];
   always_ff @(posedge clock) begin
      if (byte_sel < FRAME_BYTES) begin
         frame_bit_ff <= store_ff[IDX_W'(byte_sel)][3'd7 - bit_pos[2:0]];
      end else begin
         frame_bit_ff <= 1'b0;
      end
   end

   rcfu_unpack #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .CHANNEL_BITS  (CHANNEL_BITS),
      .POS_W         (POS_W)
   ) u_unpack (
      .clock             (clock),
      .reset             (reset),
      .start             (decode_start),
      .frame_bit         (frame_bit_ff),
      .bit_pos           (bit_pos),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule
